FILE: hw/rtl/tvc_pkg.sv
// Shared types, widths and codes for the tile visibility cull unit.
package tvc_pkg;

   localparam int NUM_PLANES  = 6;
   localparam int COORD_WIDTH = 48;
   localparam int NORM_W      = 32;
   localparam int NORM_FRAC   = 30;
   localparam int PIDX_W      = 3;
   localparam int RADIUS_W    = COORD_WIDTH - 1;
   localparam int PLANE_AW    = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

   // Exact widths of the intermediate terms.
   localparam int VEC_W  = COORD_WIDTH + 1;
   localparam int LEN_W  = 2 * COORD_WIDTH + 3;
   localparam int K_W    = 2 * COORD_WIDTH + 2;
   localparam int CC_W   = 2 * COORD_WIDTH + 1;
   localparam int R2_W   = 2 * COORD_WIDTH - 2;
   localparam int PP_W   = 2 * COORD_WIDTH;
   localparam int PROD_W = 4 * COORD_WIDTH + 4;

   // Digit-serial multiplier geometry.
   localparam int DIG_W       = 8;
   localparam int MUL_AW      = LEN_W;
   localparam int MUL_BIN_W   = K_W;
   localparam int MUL_NDIG    = (2 * COORD_WIDTH + 1 + DIG_W - 1) / DIG_W;
   localparam int MUL_BW      = MUL_NDIG * DIG_W;
   localparam int NDIG_W      = $clog2(MUL_NDIG + 1);
   localparam int CORNER_NDIG = (COORD_WIDTH + DIG_W - 1) / DIG_W;
   localparam int VEC_NDIG    = (VEC_W + DIG_W - 1) / DIG_W;
   localparam int NORM_NDIG   = NORM_W / DIG_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TEST = 1'b1;

   typedef enum logic [1:0] {
      CSR_CAMERA_X       = 2'd0,
      CSR_CAMERA_Y       = 2'd1,
      CSR_CAMERA_Z       = 2'd2,
      CSR_HORIZON_RADIUS = 2'd3
   } csr_index_type;

   typedef enum logic {
      KIND_LOAD,
      KIND_TEST
   } kind_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_CAM_SQ,
      BK_RAD_SQ,
      BK_PLANE_DOT,
      BK_PLANE_CMP,
      BK_CORNER,
      BK_LEN_SQ,
      BK_K_DOT,
      BK_K_SQ,
      BK_CC_LEN,
      BK_P_SQ,
      BK_P_V,
      BK_EVAL,
      BK_REPLY
   } back_state_type;

   typedef struct packed {
      logic                          operation;
      logic [PIDX_W-1:0]             plane_index;
      logic signed [NORM_W-1:0]      plane_normal_x;
      logic signed [NORM_W-1:0]      plane_normal_y;
      logic signed [NORM_W-1:0]      plane_normal_z;
      logic signed [COORD_WIDTH-1:0] plane_offset;
      logic signed [COORD_WIDTH-1:0] box_min_x;
      logic signed [COORD_WIDTH-1:0] box_min_y;
      logic signed [COORD_WIDTH-1:0] box_min_z;
      logic signed [COORD_WIDTH-1:0] box_max_x;
      logic signed [COORD_WIDTH-1:0] box_max_y;
      logic signed [COORD_WIDTH-1:0] box_max_z;
   } req_type;

   typedef struct packed {
      logic visible;
      logic inside_frustum;
      logic above_horizon;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] camera_x;
      logic signed [COORD_WIDTH-1:0] camera_y;
      logic signed [COORD_WIDTH-1:0] camera_z;
      logic [RADIUS_W-1:0]           horizon_radius;
   } cfg_type;

   typedef struct packed {
      kind_type kind;
      req_type  item;
   } queue_entry_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_head_type;

   typedef struct packed {
      logic                        start;
      logic signed [MUL_AW-1:0]    a;
      logic signed [MUL_BIN_W-1:0] b;
      logic [NDIG_W-1:0]           ndig;
   } mul_cmd_type;

   typedef struct packed {
      logic                     done;
      logic signed [PROD_W-1:0] product;
   } mul_rsp_type;

endpackage

FILE: hw/rtl/tile_visibility_cull_unit.sv
// Top level: config registers, front queue, cull sequencer and shared multiplier.
//
//  channel   handshake                 payload      direction
//  -------   -----------------------   ----------   ---------
//  req       start / busy              req_item     in
//  rsp       rsp_valid (strobe)        rsp_item     out
//  csr       csr_we, csr_index         csr_wdata    in
//
// A test item runs setup and the six planes, then tries the corners one by one (one to
// eight) until one passes. The single shared multiplier, which takes 8 bits of one
// operand per cycle, sets how long that takes.
// Load items are written to the plane table when the back end pops them and give no result.
// Reset is synchronous and clears control state; the plane table is not cleared.
// A result is on rsp_item for one cycle while rsp_valid is high; the receiver
// cannot stall. busy rises when the two-entry item queue is full.
module tile_visibility_cull_unit import tvc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  req_type                req_item,
   output logic                   busy,
   output logic                   rsp_valid,
   output rsp_type                rsp_item,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [COORD_WIDTH-1:0] csr_wdata
);

   cfg_type        cfg_ff, cfg_in;
   queue_head_type head;
   logic           pop;
   mul_cmd_type    mcmd;
   mul_rsp_type    mrsp;

   // config registers; the user must write them only while idle, the block itself does not enforce it
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CAMERA_X:       cfg_in.camera_x       = csr_wdata;
            CSR_CAMERA_Y:       cfg_in.camera_y       = csr_wdata;
            CSR_CAMERA_Z:       cfg_in.camera_z       = csr_wdata;
            CSR_HORIZON_RADIUS: cfg_in.horizon_radius = csr_wdata[RADIUS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tvc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .busy     (busy),
      .pop      (pop),
      .head     (head)
   );

   tvc_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mcmd),
      .rsp   (mrsp)
   );

   tvc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .pop       (pop),
      .mcmd      (mcmd),
      .mrsp      (mrsp),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // result strobes never come back to back
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result strobes");

   // visible is the conjunction of both tests
   a_visible: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.visible == (rsp_item.inside_frustum && rsp_item.above_horizon)))
      else $error("visible disagrees with test flags");

   // the multiplier never gets a new operation while one is in flight
   a_mul_single: assert property (@(posedge clock) disable iff (reset)
      mcmd.start |=> !mcmd.start)
      else $error("multiplier restarted");

endmodule

FILE: hw/rtl/tvc_mul.sv
// Shared signed multiplier, one 8-bit digit of the b operand per cycle.
module tvc_mul import tvc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_cmd_type cmd,
   output mul_rsp_type rsp
);

   logic                     run_ff, run_in;
   logic                     fix_ff, fix_in;
   logic                     done_ff, done_in;
   logic [NDIG_W-1:0]        cnt_ff, cnt_in;
   logic                     neg_ff, neg_in;
   logic [MUL_AW-1:0]        a_mag_ff, a_mag_in;
   logic [MUL_BW-1:0]        b_mag_ff, b_mag_in;
   logic [PROD_W-1:0]        acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   logic                     a_neg, b_neg;
   logic [MUL_AW-1:0]        a_abs;
   logic [MUL_BIN_W-1:0]     b_abs;
   logic [DIG_W-1:0]         digit;
   logic [MUL_AW+DIG_W-1:0]  partial;

   always_comb begin
      a_neg   = cmd.a[MUL_AW-1];
      b_neg   = cmd.b[MUL_BIN_W-1];
      a_abs   = a_neg ? MUL_AW'(-cmd.a) : MUL_AW'(cmd.a);
      b_abs   = b_neg ? MUL_BIN_W'(-cmd.b) : MUL_BIN_W'(cmd.b);
      digit   = b_mag_ff[cnt_ff*DIG_W +: DIG_W];
      partial = (MUL_AW+DIG_W)'(a_mag_ff) * (MUL_AW+DIG_W)'(digit);

      run_in   = run_ff;
      fix_in   = 1'b0;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      a_mag_in = a_mag_ff;
      b_mag_in = b_mag_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;

      if (cmd.start) begin
         run_in   = 1'b1;
         cnt_in   = cmd.ndig - NDIG_W'(1);
         neg_in   = a_neg ^ b_neg;
         a_mag_in = a_abs;
         b_mag_in = MUL_BW'(b_abs);
         acc_in   = '0;
      end else if (run_ff) begin
         // msb-first: shift in one digit's worth of partial product
         acc_in = (acc_ff << DIG_W) + PROD_W'(partial);
         if (cnt_ff == '0) begin
            run_in = 1'b0;
            fix_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - NDIG_W'(1);
         end
      end

      if (fix_ff) begin
         prod_in = neg_ff ? $signed(-acc_ff) : $signed(acc_ff);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      neg_ff   <= neg_in;
      a_mag_ff <= a_mag_in;
      b_mag_ff <= b_mag_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.product = prod_ff;

endmodule

FILE: hw/rtl/tvc_front.sv
// Front end: accepts items, classifies them and queues them for the back end.
module tvc_front import tvc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  req_type        req_item,
   output logic           busy,
   input  logic           pop,
   output queue_head_type head
);

   localparam logic [PIDX_W:0] NUM_PLANES_CMP = (PIDX_W+1)'(NUM_PLANES);

   queue_entry_type       entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;

   logic                  accept;
   logic                  push;
   logic                  do_pop;
   queue_entry_type       new_entry;

   always_comb begin
      busy   = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
      accept = start && !busy;
      new_entry.kind = (req_item.operation == OP_TEST) ? KIND_TEST : KIND_LOAD;
      new_entry.item = req_item;
      // loads to a plane slot that does not exist are dropped here
      push   = accept && ((req_item.operation == OP_TEST) ||
                          ({1'b0, req_item.plane_index} < NUM_PLANES_CMP));
      do_pop = pop && (count_ff != '0);

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + QUEUE_AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + QUEUE_AW'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + QUEUE_CW'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - QUEUE_CW'(1);
      end

      head.valid = (count_ff != '0);
      head.entry = entries_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

FILE: hw/rtl/tvc_back.sv
// Back end: plane table, test sequencer and exact compare logic.
module tvc_back import tvc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  queue_head_type head,
   output logic           pop,
   output mul_cmd_type    mcmd,
   input  mul_rsp_type    mrsp,
   output logic           rsp_valid,
   output rsp_type        rsp_item
);

   localparam logic [1:0] LAST_AXIS   = 2'd2;
   localparam logic [2:0] LAST_CORNER = 3'd7;

   back_state_type state_ff, state_in;

   logic                  wait_ff, wait_in;
   logic [1:0]            axis_ff, axis_in;
   logic [PLANE_AW-1:0]   plane_ff, plane_in;
   logic [2:0]            corner_ff, corner_in;
   logic                  inside_ff, inside_in;
   logic                  above_ff, above_in;

   req_type                  item_ff, item_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic signed [CC_W-1:0]   cc_ff, cc_in;
   logic [R2_W-1:0]          r2_ff, r2_in;
   logic signed [LEN_W-1:0]  len2_ff, len2_in;
   logic signed [K_W-1:0]    k_ff, k_in;
   logic signed [PROD_W-1:0] ksq_ff, ksq_in;
   logic                     cond1_ff, cond1_in;
   logic [PP_W-1:0]          pp_ff, pp_in;
   logic signed [K_W-1:0]    pv_ff, pv_in;
   logic signed [VEC_W-1:0]  v_ff [3];
   logic signed [VEC_W-1:0]  v_in [3];

   logic signed [NORM_W-1:0]      plane_nx_ff  [NUM_PLANES];
   logic signed [NORM_W-1:0]      plane_ny_ff  [NUM_PLANES];
   logic signed [NORM_W-1:0]      plane_nz_ff  [NUM_PLANES];
   logic signed [COORD_WIDTH-1:0] plane_off_ff [NUM_PLANES];

   logic signed [COORD_WIDTH-1:0] cam_arr [3];
   logic signed [COORD_WIDTH-1:0] lo_arr  [3];
   logic signed [COORD_WIDTH-1:0] hi_arr  [3];
   logic signed [COORD_WIDTH-1:0] p_arr   [3];
   logic signed [COORD_WIDTH-1:0] cam_ax, lo_ax, hi_ax, p_ax;
   logic signed [VEC_W-1:0]       v_ax;
   logic signed [NORM_W-1:0]      n_ax;

   logic                     is_mul, is_dot, step_done, load_pop;
   logic signed [PROD_W-1:0] acc_base, dot_sum, limit;
   logic                     pass;
   logic [PLANE_AW-1:0]      wr_idx;

   // operand views
   always_comb begin
      cam_arr[0] = cfg.camera_x;
      cam_arr[1] = cfg.camera_y;
      cam_arr[2] = cfg.camera_z;
      lo_arr[0]  = item_ff.box_min_x;
      lo_arr[1]  = item_ff.box_min_y;
      lo_arr[2]  = item_ff.box_min_z;
      hi_arr[0]  = item_ff.box_max_x;
      hi_arr[1]  = item_ff.box_max_y;
      hi_arr[2]  = item_ff.box_max_z;
      for (int a = 0; a < 3; a++) begin
         p_arr[a] = corner_ff[a] ? hi_arr[a] : lo_arr[a];
      end
      cam_ax = cam_arr[axis_ff];
      lo_ax  = lo_arr[axis_ff];
      hi_ax  = hi_arr[axis_ff];
      p_ax   = p_arr[axis_ff];
      v_ax   = v_ff[axis_ff];
      case (axis_ff)
         2'd0:    n_ax = plane_nx_ff[plane_ff];
         2'd1:    n_ax = plane_ny_ff[plane_ff];
         default: n_ax = plane_nz_ff[plane_ff];
      endcase
   end

   // outputs and multiplier operands
   always_comb begin
      pop       = 1'b0;
      is_mul    = 1'b0;
      is_dot    = 1'b0;
      mcmd.a    = '0;
      mcmd.b    = '0;
      mcmd.ndig = NDIG_W'(1);
      unique case (state_ff) inside
         BK_IDLE: begin
            pop = head.valid;
         end
         BK_CAM_SQ: begin
            is_mul = 1'b1; is_dot = 1'b1;
            mcmd.a = MUL_AW'(cam_ax); mcmd.b = MUL_BIN_W'(cam_ax);
            mcmd.ndig = NDIG_W'(CORNER_NDIG);
         end
         BK_RAD_SQ: begin
            is_mul = 1'b1;
            mcmd.a = MUL_AW'(cfg.horizon_radius); mcmd.b = MUL_BIN_W'(cfg.horizon_radius);
            mcmd.ndig = NDIG_W'(CORNER_NDIG);
         end
         BK_PLANE_DOT: begin
            // per axis, the larger of n*lo and n*hi; min and max may be swapped
            is_mul = 1'b1; is_dot = 1'b1;
            mcmd.a = (n_ax[NORM_W-1] == (hi_ax < lo_ax)) ? MUL_AW'(hi_ax) : MUL_AW'(lo_ax);
            mcmd.b = MUL_BIN_W'(n_ax);
            mcmd.ndig = NDIG_W'(NORM_NDIG);
         end
         BK_LEN_SQ: begin
            is_mul = 1'b1; is_dot = 1'b1;
            mcmd.a = MUL_AW'(v_ax); mcmd.b = MUL_BIN_W'(v_ax);
            mcmd.ndig = NDIG_W'(VEC_NDIG);
         end
         BK_K_DOT: begin
            is_mul = 1'b1; is_dot = 1'b1;
            mcmd.a = MUL_AW'(v_ax); mcmd.b = MUL_BIN_W'(cam_ax);
            mcmd.ndig = NDIG_W'(CORNER_NDIG);
         end
         BK_K_SQ: begin
            is_mul = 1'b1;
            mcmd.a = MUL_AW'(k_ff); mcmd.b = k_ff;
            mcmd.ndig = NDIG_W'(MUL_NDIG);
         end
         BK_CC_LEN: begin
            is_mul = 1'b1;
            mcmd.a = MUL_AW'(len2_ff); mcmd.b = MUL_BIN_W'(cc_ff);
            mcmd.ndig = NDIG_W'(MUL_NDIG);
         end
         BK_P_SQ: begin
            is_mul = 1'b1; is_dot = 1'b1;
            mcmd.a = MUL_AW'(p_ax); mcmd.b = MUL_BIN_W'(p_ax);
            mcmd.ndig = NDIG_W'(CORNER_NDIG);
         end
         BK_P_V: begin
            is_mul = 1'b1; is_dot = 1'b1;
            mcmd.a = MUL_AW'(v_ax); mcmd.b = MUL_BIN_W'(p_ax);
            mcmd.ndig = NDIG_W'(CORNER_NDIG);
         end
         default: ;
      endcase
      mcmd.start = is_mul && !wait_ff;
      step_done  = is_mul && mrsp.done && (!is_dot || (axis_ff == LAST_AXIS));
      load_pop   = pop && (head.entry.kind == KIND_LOAD);
      rsp_valid  = (state_ff == BK_REPLY);
      rsp_item.inside_frustum = inside_ff;
      rsp_item.above_horizon  = above_ff;
      rsp_item.visible        = inside_ff && above_ff;
   end

   // corner verdict
   always_comb begin
      pass = (len2_ff != '0) &&
             (cond1_ff || ((k_ff > 0) && (cc_ff > 0)) ||
              ((PP_W'(r2_ff) < pp_ff) && pv_ff[K_W-1]));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:      if (pop && (head.entry.kind == KIND_TEST)) state_in = BK_CAM_SQ;
         BK_CAM_SQ:    if (step_done) state_in = BK_RAD_SQ;
         BK_RAD_SQ:    if (step_done) state_in = BK_PLANE_DOT;
         BK_PLANE_DOT: if (step_done) state_in = BK_PLANE_CMP;
         BK_PLANE_CMP: begin
            state_in = (plane_ff == PLANE_AW'(NUM_PLANES-1)) ? BK_CORNER : BK_PLANE_DOT;
         end
         BK_CORNER:    state_in = BK_LEN_SQ;
         BK_LEN_SQ:    if (step_done) state_in = BK_K_DOT;
         BK_K_DOT:     if (step_done) state_in = BK_K_SQ;
         BK_K_SQ:      if (step_done) state_in = BK_CC_LEN;
         BK_CC_LEN:    if (step_done) state_in = BK_P_SQ;
         BK_P_SQ:      if (step_done) state_in = BK_P_V;
         BK_P_V:       if (step_done) state_in = BK_EVAL;
         BK_EVAL: begin
            state_in = (pass || (corner_ff == LAST_CORNER)) ? BK_REPLY : BK_CORNER;
         end
         BK_REPLY:     state_in = BK_IDLE;
         default:      state_in = BK_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      acc_base = (axis_ff == 2'd0) ? PROD_W'(0) : acc_ff;
      dot_sum  = acc_base + mrsp.product;
      limit    = PROD_W'(plane_off_ff[plane_ff]) <<< NORM_FRAC;

      wait_in   = wait_ff;
      axis_in   = axis_ff;
      plane_in  = plane_ff;
      corner_in = corner_ff;
      inside_in = inside_ff;
      above_in  = above_ff;
      item_in   = item_ff;
      acc_in    = acc_ff;
      cc_in     = cc_ff;
      r2_in     = r2_ff;
      len2_in   = len2_ff;
      k_in      = k_ff;
      ksq_in    = ksq_ff;
      cond1_in  = cond1_ff;
      pp_in     = pp_ff;
      pv_in     = pv_ff;
      for (int a = 0; a < 3; a++) begin
         v_in[a] = v_ff[a];
      end

      if (mcmd.start) begin
         wait_in = 1'b1;
      end
      if (is_mul && mrsp.done) begin
         wait_in = 1'b0;
         acc_in  = dot_sum;
         axis_in = (!is_dot || (axis_ff == LAST_AXIS)) ? 2'd0 : axis_ff + 2'd1;
      end

      if (step_done) begin
         case (state_ff)
            BK_RAD_SQ: begin
               r2_in = R2_W'(mrsp.product);
               cc_in = CC_W'(acc_ff - mrsp.product);
            end
            BK_LEN_SQ: len2_in  = LEN_W'(dot_sum);
            BK_K_DOT:  k_in     = K_W'(dot_sum);
            BK_K_SQ:   ksq_in   = mrsp.product;
            BK_CC_LEN: cond1_in = (mrsp.product > ksq_ff);
            BK_P_SQ:   pp_in    = PP_W'(dot_sum);
            BK_P_V:    pv_in    = K_W'(dot_sum);
            default: ;
         endcase
      end

      case (state_ff)
         BK_IDLE: begin
            if (pop) begin
               item_in   = head.entry.item;
               inside_in = 1'b1;
               above_in  = 1'b0;
               plane_in  = '0;
               corner_in = '0;
               axis_in   = 2'd0;
               wait_in   = 1'b0;
            end
         end
         BK_PLANE_CMP: begin
            // some corner reaches the offset exactly when the best corner does
            if (acc_ff < limit) inside_in = 1'b0;
            plane_in = plane_ff + PLANE_AW'(1);
         end
         BK_CORNER: begin
            for (int a = 0; a < 3; a++) begin
               v_in[a] = VEC_W'(p_arr[a]) - VEC_W'(cam_arr[a]);
            end
         end
         BK_EVAL: begin
            if (pass) above_in = 1'b1;
            corner_in = corner_ff + 3'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         wait_ff   <= 1'b0;
         axis_ff   <= 2'd0;
         plane_ff  <= '0;
         corner_ff <= '0;
         inside_ff <= 1'b0;
         above_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         wait_ff   <= wait_in;
         axis_ff   <= axis_in;
         plane_ff  <= plane_in;
         corner_ff <= corner_in;
         inside_ff <= inside_in;
         above_ff  <= above_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      acc_ff   <= acc_in;
      cc_ff    <= cc_in;
      r2_ff    <= r2_in;
      len2_ff  <= len2_in;
      k_ff     <= k_in;
      ksq_ff   <= ksq_in;
      cond1_ff <= cond1_in;
      pp_ff    <= pp_in;
      pv_ff    <= pv_in;
      for (int a = 0; a < 3; a++) begin
         v_ff[a] <= v_in[a];
      end
   end

   // plane table, written by load items only
   assign wr_idx = head.entry.item.plane_index[PLANE_AW-1:0];

   always_ff @(posedge clock) begin
      if (load_pop) begin
         plane_nx_ff[wr_idx]  <= head.entry.item.plane_normal_x;
         plane_ny_ff[wr_idx]  <= head.entry.item.plane_normal_y;
         plane_nz_ff[wr_idx]  <= head.entry.item.plane_normal_z;
         plane_off_ff[wr_idx] <= head.entry.item.plane_offset;
      end
   end

endmodule
